### hw/rtl/ftrl_pkg.sv
`default_nettype none

package ftrl_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_W  = 24;
  localparam int unsigned IDX_W  = 10;

  // iterative unit geometry
  localparam int unsigned OPND_W  = 64;
  localparam int unsigned DVS_W   = 48;
  localparam int unsigned RES_W   = 48;
  localparam int unsigned REM_W   = 49;
  localparam int unsigned CNT_W   = 6;
  localparam logic [CNT_W-1:0] DIV_STEPS  = 6'd48;
  localparam logic [CNT_W-1:0] SQRT_STEPS = 6'd32;

  // register indexes
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_L1    = 2'd2;
  localparam logic [1:0] REG_L2    = 2'd3;

  localparam logic [CFG_W-1:0] ALPHA_RST = 24'd65536;
  localparam logic [CFG_W-1:0] BETA_RST  = 24'd65536;
  localparam logic [CFG_W-1:0] L1_RST    = 24'd0;
  localparam logic [CFG_W-1:0] L2_RST    = 24'd65536;

  // sqrt of the saturated n (0xFFFFFFFF in Q16.16)
  localparam logic [23:0] SQRT_NMAX = 24'hFFFFFF;
  localparam logic [40:0] PROD_MAX  = 41'h100_0000_0000;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } itu_op_t;

  typedef struct packed {
    logic                start;
    itu_op_t             op;
    logic [OPND_W-1:0]   opnd;
    logic [DVS_W-1:0]    dvs;
  } itu_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] w;
  } coord_row_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_SQG,
    ST_NSUM,
    ST_RTN_GO,
    ST_RTN_WAIT,
    ST_RTO_GO,
    ST_RTO_WAIT,
    ST_SIG_GO,
    ST_SIG_WAIT,
    ST_MULH,
    ST_MULL,
    ST_PSUM,
    ST_ZUPD,
    ST_DEN_GO,
    ST_DEN_WAIT,
    ST_QUO_GO,
    ST_QUO_WAIT,
    ST_WRITE,
    ST_OUT
  } ftrl_state_t;

endpackage

`default_nettype wire

### hw/rtl/ftrl_itu.sv
`default_nettype none

// Bit-serial unit: restoring divide (one quotient bit a cycle) or
// digit-by-digit square root (one root bit a cycle). Operand is MSB-aligned.
module ftrl_itu
  import ftrl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire itu_cmd_t         cmd,
  output logic                  done,
  output logic [RES_W-1:0]      res
);

  logic                busy;
  itu_op_t             op;
  logic [CNT_W-1:0]    cnt;
  logic [REM_W-1:0]    rem;
  logic [OPND_W-1:0]   opnd;
  logic [DVS_W-1:0]    dvs;

  logic [REM_W:0]      shin;
  logic [REM_W:0]      trial;
  logic [REM_W:0]      diff;
  logic                ge;

  always_comb begin
    if (op == OP_SQRT) begin
      shin  = {rem[REM_W-2:0], opnd[OPND_W-1 -: 2]};
      trial = {res[RES_W-1:0], 2'b01};
    end else begin
      shin  = {rem, opnd[OPND_W-1]};
      trial = {2'b00, dvs};
    end
    ge   = (shin >= trial);
    diff = shin - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= (cmd.op == OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op   <= cmd.op;
      opnd <= cmd.opnd;
      dvs  <= cmd.dvs;
      rem  <= '0;
      res  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[REM_W-1:0] : shin[REM_W-1:0];
      res  <= {res[RES_W-2:0], ge};
      opnd <= (op == OP_SQRT) ? {opnd[OPND_W-3:0], 2'b00} : {opnd[OPND_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ftrl_store.sv
`default_nettype none

// Per-coordinate z/n/w rows; clears itself after reset, one row a cycle.
module ftrl_store
  import ftrl_pkg::*;
#(
  parameter int unsigned NUM_COORDS = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [$clog2(NUM_COORDS)-1:0] rd_addr,
  output coord_row_t                         rd_data,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(NUM_COORDS)-1:0] wr_addr,
  input  wire coord_row_t                    wr_data,
  output logic                               ready
);

  localparam int unsigned AW = $clog2(NUM_COORDS);

  coord_row_t       mem [NUM_COORDS];
  logic             clearing;
  logic [AW-1:0]    clr_addr;

  assign ready = !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(NUM_COORDS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/ftrl_coordinate_update.sv
`default_nettype none

// FTRL-Proximal per-coordinate update engine. Each transaction on the input
// channel carries a coordinate and its Q16.16 gradient; one result with the
// new weight comes back per input. The work runs on a single bit-serial
// sqrt/divide unit (two 32-step square roots, up to three 48-step divides)
// plus one shared 32x32 multiplier; the last two divides are skipped when
// the new weight is zero, an index beyond NUM_COORDS skips all of the work,
// and an item also waits while its result is held back by out_stall.
// Input is stalled while an item is in flight. After reset the coordinate
// store clears itself before the first item is taken; register writes are
// accepted during that time.
module ftrl_coordinate_update
  import ftrl_pkg::*;
#(
  parameter int unsigned NUM_COORDS = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [IDX_W-1:0]    coord_index,
  input  wire logic signed [31:0]  gradient,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [IDX_W-1:0]         coord_echo,
  output logic signed [31:0]       new_weight,
  output logic                     saturated
);

  localparam int unsigned AW = $clog2(NUM_COORDS);
  localparam logic [31:0] NUM_COORDS_W = 32'(NUM_COORDS);

  ftrl_state_t state, state_next;

  logic [CFG_W-1:0] alpha, beta, l1, l2;
  logic [CFG_W-1:0] alpha_eff;

  logic [IDX_W-1:0] idx;
  logic [31:0]      g;
  coord_row_t       row;
  coord_row_t       rd_data;
  logic             store_ready;
  logic             in_range;

  logic [63:0]      mul_q;
  logic [31:0]      mul_a, mul_b;
  logic [46:0]      nsum;
  logic             sat;
  logic [31:0]      rt_new, rt_old;
  logic [47:0]      sigma;
  logic [63:0]      hiprod;
  logic [40:0]      pmag;
  logic [31:0]      znew;
  logic [31:0]      zmag;
  logic [42:0]      den;
  logic [31:0]      wnew;

  itu_cmd_t         cmd;
  logic             itu_done;
  logic [RES_W-1:0] itu_res;

  logic [31:0]      gmag, wmag;
  logic [64:0]      psum;
  logic signed [43:0] zsum;
  logic [25:0]      s_sum;
  logic [31:0]      num;

  assign alpha_eff = (alpha == '0) ? CFG_W'(1) : alpha;
  assign in_range  = ({22'd0, idx} < NUM_COORDS_W);
  assign in_stall  = (state != ST_IDLE) || !store_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RST;
      beta  <= BETA_RST;
      l1    <= L1_RST;
      l2    <= L2_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA: alpha <= cfg_data;
        REG_BETA:  beta  <= cfg_data;
        REG_L1:    l1    <= cfg_data;
        REG_L2:    l2    <= cfg_data;
        default: ;
      endcase
    end
  end

  ftrl_store #(.NUM_COORDS(NUM_COORDS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (AW'(idx)),
    .rd_data (rd_data),
    .wr_en   (state == ST_WRITE),
    .wr_addr (AW'(idx)),
    .wr_data ({znew, (sat && nsum > 47'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : nsum[31:0], wnew}),
    .ready   (store_ready)
  );

  ftrl_itu u_itu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .done (itu_done),
    .res  (itu_res)
  );

  assign gmag  = g[31] ? (~g + 1'b1) : g;
  assign wmag  = row.w[31] ? (~row.w + 1'b1) : row.w;
  assign psum  = {1'b0, hiprod} + {17'd0, mul_q[63:16]};
  assign s_sum = {2'b00, beta} + {2'b00, (nsum > 47'h0_FFFF_FFFF) ? SQRT_NMAX : rt_new[23:0]};
  assign num   = zmag - {8'd0, l1};

  // z + g - sign(w)*pmag
  always_comb begin
    if (row.w[31]) begin
      zsum = {{12{row.z[31]}}, row.z} + {{12{g[31]}}, g} + {3'b000, pmag};
    end else begin
      zsum = {{12{row.z[31]}}, row.z} + {{12{g[31]}}, g} - {3'b000, pmag};
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (state)
      ST_SQG: begin
        mul_a = gmag;
        mul_b = gmag;
      end
      ST_MULH: begin
        mul_a = sigma[47:16];
        mul_b = wmag;
      end
      default: begin
        mul_a = {16'd0, sigma[15:0]};
        mul_b = wmag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_q <= 64'(mul_a) * 64'(mul_b);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = OP_DIV;
    unique case (state)
      ST_IDLE:     if (in_valid && !in_stall) state_next = ST_READ;
      ST_READ:     state_next = in_range ? ST_SQG : ST_OUT;
      ST_SQG:      state_next = ST_NSUM;
      ST_NSUM:     state_next = ST_RTN_GO;
      ST_RTN_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_SQRT;
        cmd.opnd   = {1'b0, nsum, 16'd0};
        state_next = ST_RTN_WAIT;
      end
      ST_RTN_WAIT: if (itu_done) state_next = ST_RTO_GO;
      ST_RTO_GO: begin
        cmd.start  = 1'b1;
        cmd.op     = OP_SQRT;
        cmd.opnd   = {16'd0, row.n, 16'd0};
        state_next = ST_RTO_WAIT;
      end
      ST_RTO_WAIT: if (itu_done) state_next = ST_SIG_GO;
      ST_SIG_GO: begin
        cmd.start  = 1'b1;
        cmd.opnd   = {rt_new - rt_old, 32'd0};
        cmd.dvs    = {24'd0, alpha_eff};
        state_next = ST_SIG_WAIT;
      end
      ST_SIG_WAIT: if (itu_done) state_next = ST_MULH;
      ST_MULH:     state_next = ST_MULL;
      ST_MULL:     state_next = ST_PSUM;
      ST_PSUM:     state_next = ST_ZUPD;
      ST_ZUPD:     state_next = ST_DEN_GO;
      ST_DEN_GO: begin
        if (zmag <= {8'd0, l1}) begin
          state_next = ST_WRITE;
        end else begin
          cmd.start  = 1'b1;
          cmd.opnd   = {6'd0, s_sum, 32'd0};
          cmd.dvs    = {24'd0, alpha_eff};
          state_next = ST_DEN_WAIT;
        end
      end
      ST_DEN_WAIT: if (itu_done) state_next = ST_QUO_GO;
      ST_QUO_GO: begin
        // a zero divisor yields an all-ones quotient, which clips like the
        // overflow case
        cmd.start  = 1'b1;
        cmd.opnd   = {num, 32'd0};
        cmd.dvs    = {5'd0, den};
        state_next = ST_QUO_WAIT;
      end
      ST_QUO_WAIT: if (itu_done) state_next = ST_WRITE;
      ST_WRITE:    state_next = ST_OUT;
      ST_OUT:      if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx  <= coord_index;
        g    <= gradient;
        sat  <= 1'b0;
        wnew <= '0;
      end
      ST_SQG:  row <= rd_data;
      ST_NSUM: begin
        // g*g reaches 2^62 for the most negative gradient
        nsum <= {15'd0, row.n} + mul_q[62:16];
        sat  <= ({15'd0, row.n} + mul_q[62:16]) > 47'h0_FFFF_FFFF;
      end
      ST_RTN_WAIT: if (itu_done) rt_new <= itu_res[31:0];
      ST_RTO_WAIT: if (itu_done) rt_old <= itu_res[31:0];
      ST_SIG_WAIT: if (itu_done) sigma <= itu_res;
      ST_MULL: hiprod <= mul_q;
      ST_PSUM: pmag <= (psum > {24'd0, PROD_MAX}) ? PROD_MAX : psum[40:0];
      ST_ZUPD: begin
        if (zsum > 44'sh0_7FFF_FFFF) begin
          znew <= 32'h7FFF_FFFF;
          zmag <= 32'h7FFF_FFFF;
          sat  <= 1'b1;
        end else if (zsum < -44'sh0_8000_0000) begin
          znew <= 32'h8000_0000;
          zmag <= 32'h8000_0000;
          sat  <= 1'b1;
        end else begin
          znew <= zsum[31:0];
          zmag <= zsum[43] ? (~zsum[31:0] + 1'b1) : zsum[31:0];
        end
      end
      ST_DEN_WAIT: if (itu_done) den <= itu_res[42:0] + {19'd0, l2};
      ST_QUO_WAIT: begin
        if (itu_done) begin
          if (!znew[31]) begin
            wnew <= (itu_res > 48'h0000_8000_0000) ? 32'h8000_0000
                                                   : (~itu_res[31:0] + 1'b1);
          end else begin
            wnew <= (itu_res > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : itu_res[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!out_valid || !out_stall)) begin
      coord_echo <= idx;
      new_weight <= wnew;
      saturated  <= sat;
    end
  end

endmodule

`default_nettype wire
